### design/dsrpc_pkg.sv
// ----------------------------------------------------------------------------
// dsrpc_pkg
// Shared types and MIPS32 encodings for the delay-slot resume PC block.
// ----------------------------------------------------------------------------
package dsrpc_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned RIDX = 5;

  localparam logic [RIDX-1:0] LINK_REG = 5'd31;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_BEQL    = 6'h14;
  localparam logic [5:0] OP_BNEL    = 6'h15;
  localparam logic [5:0] OP_BLEZL   = 6'h16;
  localparam logic [5:0] OP_BGTZL   = 6'h17;

  // SPECIAL function codes
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_JALR = 6'h09;

  // REGIMM rt codes
  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  // where the resume address comes from
  typedef enum logic [2:0] {
    KIND_SEQ4,   // not in a delay slot: pc+4
    KIND_SEQ8,   // unknown instruction: branch+8
    KIND_REG,    // register jump
    KIND_JUMP,   // region jump
    KIND_COND    // conditional branch
  } kind_t;

  typedef enum logic [2:0] {
    COND_EQ,
    COND_NE,
    COND_LEZ,
    COND_GTZ,
    COND_LTZ,
    COND_GEZ
  } cond_t;

  typedef struct packed {
    kind_t           kind;
    cond_t           cond;
    logic            link_write;
    logic [RIDX-1:0] link_index;
  } dec_t;

endpackage

### design/dsrpc_decode.sv
// ----------------------------------------------------------------------------
// dsrpc_decode
// Classifies the branch or jump word into a target kind, a branch condition
// and the link register write.
// ----------------------------------------------------------------------------
module dsrpc_decode import dsrpc_pkg::*; (
  input  logic             delay_slot,
  input  logic [XLEN-1:0]  word,
  output dec_t             dec
);

  logic [5:0]      op;
  logic [4:0]      rtf;
  logic [RIDX-1:0] rdf;
  logic [5:0]      fn;

  assign op  = word[31:26];
  assign rtf = word[20:16];
  assign rdf = word[15:11];
  assign fn  = word[5:0];

  always_comb begin
    dec.kind       = KIND_SEQ8;
    dec.cond       = COND_EQ;
    dec.link_write = 1'b0;
    dec.link_index = '0;
    if (!delay_slot) begin
      dec.kind = KIND_SEQ4;
    end else begin
      case (op)
        OP_SPECIAL: begin
          if (fn == FN_JR) begin
            dec.kind = KIND_REG;
          end else if (fn == FN_JALR) begin
            dec.kind       = KIND_REG;
            dec.link_write = 1'b1;
            dec.link_index = rdf;
          end
        end
        OP_REGIMM: begin
          case (rtf)
            RI_BLTZ: begin
              dec.kind = KIND_COND;
              dec.cond = COND_LTZ;
            end
            RI_BGEZ: begin
              dec.kind = KIND_COND;
              dec.cond = COND_GEZ;
            end
            RI_BLTZAL: begin
              dec.kind       = KIND_COND;
              dec.cond       = COND_LTZ;
              dec.link_write = 1'b1;
              dec.link_index = LINK_REG;
            end
            RI_BGEZAL: begin
              dec.kind       = KIND_COND;
              dec.cond       = COND_GEZ;
              dec.link_write = 1'b1;
              dec.link_index = LINK_REG;
            end
            default: begin
              dec.kind = KIND_SEQ8;
            end
          endcase
        end
        OP_J: begin
          dec.kind = KIND_JUMP;
        end
        OP_JAL: begin
          dec.kind       = KIND_JUMP;
          dec.link_write = 1'b1;
          dec.link_index = LINK_REG;
        end
        // likely forms share the condition and never link
        OP_BEQ, OP_BEQL: begin
          dec.kind = KIND_COND;
          dec.cond = COND_EQ;
        end
        OP_BNE, OP_BNEL: begin
          dec.kind = KIND_COND;
          dec.cond = COND_NE;
        end
        OP_BLEZ, OP_BLEZL: begin
          dec.kind = KIND_COND;
          dec.cond = COND_LEZ;
        end
        OP_BGTZ, OP_BGTZL: begin
          dec.kind = KIND_COND;
          dec.cond = COND_GTZ;
        end
        default: begin
          dec.kind = KIND_SEQ8;
        end
      endcase
    end
  end

endmodule

### design/delay_slot_resume_pc.sv
// ----------------------------------------------------------------------------
// delay_slot_resume_pc
// Resume address and link write after an emulated trap, MIPS32 branch rules.
// ----------------------------------------------------------------------------
// A transaction is taken whenever start is high; busy stays low, so one
// transaction can enter every clock cycle. Each result appears on the out_
// ports for one cycle, marked by out_valid, in the order the transactions
// came in. It passes through three register stages: decode and register
// compare, then the address adds and condition check, then the final
// select into the output register. The receiver cannot hold results off,
// so they must be taken when shown.
// ----------------------------------------------------------------------------
module delay_slot_resume_pc import dsrpc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [XLEN-1:0]  in_exc_pc,
  input  logic             in_in_delay_slot,
  input  logic [XLEN-1:0]  in_branch_word,
  input  logic [XLEN-1:0]  in_rs_value,
  input  logic [XLEN-1:0]  in_rt_value,
  output logic             out_valid,
  output logic [XLEN-1:0]  out_next_pc,
  output logic             out_link_write,
  output logic [RIDX-1:0]  out_link_index,
  output logic [XLEN-1:0]  out_link_value
);

  logic accept;
  dec_t dec;

  // stage 1
  logic            s1_vld_r;
  dec_t            s1_dec_r;
  logic [XLEN-1:0] s1_pc4_r;
  logic [XLEN-1:0] s1_rs_r;
  logic [25:0]     s1_idx_r;
  logic            s1_eq_r;
  logic            s1_zero_r;

  // stage 2
  logic            s2_vld_r;
  logic            s2_use_alt_r;
  logic [XLEN-1:0] s2_alt_r;
  logic [XLEN-1:0] s2_seq_r;
  logic            s2_lw_r;
  logic [RIDX-1:0] s2_li_r;

  logic [XLEN-1:0] s2_seq_nxt;
  logic [XLEN-1:0] s2_rel_nxt;
  logic [XLEN-1:0] s2_alt_nxt;
  logic            s2_use_alt_nxt;
  logic            taken;
  logic            neg;

  // output stage
  logic            out_vld_r;
  logic [XLEN-1:0] out_npc_r;
  logic            out_lw_r;
  logic [RIDX-1:0] out_li_r;
  logic [XLEN-1:0] out_lv_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dsrpc_decode u_decode (
    .delay_slot (in_in_delay_slot),
    .word       (in_branch_word),
    .dec        (dec)
  );

  // ---- stage 1: decode, pc+4, register compares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dec_r  <= dec;
      s1_pc4_r  <= in_exc_pc + XLEN'(4);
      s1_rs_r   <= in_rs_value;
      // offset and jump index both live in the low bits of the word
      s1_idx_r  <= in_branch_word[25:0];
      s1_eq_r   <= (in_rs_value == in_rt_value);
      s1_zero_r <= (in_rs_value == '0);
    end
  end

  // ---- stage 2: address adds and condition
  assign neg        = s1_rs_r[XLEN-1];
  assign s2_seq_nxt = s1_pc4_r + XLEN'(4);
  assign s2_rel_nxt = s1_pc4_r + {{(XLEN-18){s1_idx_r[15]}}, s1_idx_r[15:0], 2'b00};

  always_comb begin
    case (s1_dec_r.cond)
      COND_EQ:  taken = s1_eq_r;
      COND_NE:  taken = !s1_eq_r;
      COND_LEZ: taken = neg || s1_zero_r;
      COND_GTZ: taken = !neg && !s1_zero_r;
      COND_LTZ: taken = neg;
      COND_GEZ: taken = !neg;
      default:  taken = 1'b0;
    endcase
  end

  always_comb begin
    case (s1_dec_r.kind)
      KIND_SEQ4: begin
        s2_alt_nxt     = s1_pc4_r;
        s2_use_alt_nxt = 1'b1;
      end
      KIND_REG: begin
        s2_alt_nxt     = s1_rs_r;
        s2_use_alt_nxt = 1'b1;
      end
      KIND_JUMP: begin
        s2_alt_nxt     = {s1_pc4_r[XLEN-1:28], s1_idx_r, 2'b00};
        s2_use_alt_nxt = 1'b1;
      end
      KIND_COND: begin
        s2_alt_nxt     = s2_rel_nxt;
        s2_use_alt_nxt = taken;
      end
      default: begin
        s2_alt_nxt     = s2_rel_nxt;
        s2_use_alt_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_alt_r     <= s2_alt_nxt;
      s2_use_alt_r <= s2_use_alt_nxt;
      s2_seq_r     <= s2_seq_nxt;
      s2_lw_r      <= s1_dec_r.link_write;
      s2_li_r      <= s1_dec_r.link_index;
    end
  end

  // ---- stage 3: final select into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      out_npc_r <= s2_use_alt_r ? s2_alt_r : s2_seq_r;
      out_lw_r  <= s2_lw_r;
      out_li_r  <= s2_lw_r ? s2_li_r : '0;
      out_lv_r  <= s2_lw_r ? s2_seq_r : '0;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_next_pc    = out_npc_r;
  assign out_link_write = out_lw_r;
  assign out_link_index = out_li_r;
  assign out_link_value = out_lv_r;

  // ---- assertions
  a_out_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3))
    else $error("result strobe without a transaction three cycles earlier");

  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> $past(s1_vld_r))
    else $error("stage 2 valid without stage 1 valid");

  a_no_link_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_link_write) |-> (out_link_index == '0 && out_link_value == '0))
    else $error("link fields not cleared without a link write");

endmodule
